@@ rtl/core/tfcp_pkg.sv @@
// Package for the text frame checksum parser.
// Holds event codes, parse state codes, the label key and the matcher functions.
// No dependencies.
package tfcp_pkg;

	// Event codes reported with every result.
	localparam logic [2:0] EV_IGNORED    = 3'd0;
	localparam logic [2:0] EV_FRAME_START = 3'd1;
	localparam logic [2:0] EV_LABEL_CHAR = 3'd2;
	localparam logic [2:0] EV_LABEL_END  = 3'd3;
	localparam logic [2:0] EV_VALUE_CHAR = 3'd4;
	localparam logic [2:0] EV_FIELD_END  = 3'd5;
	localparam logic [2:0] EV_CHECKED    = 3'd6;

	// Parse state codes.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_NAME  = 2'd1;
	localparam logic [1:0] ST_VALUE = 2'd2;
	localparam logic [1:0] ST_CHECK = 2'd3;

	// Special characters.
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;

	// Length of the key label at the width of the match progress.
	localparam logic [3:0] KEY_LEN_W = 4'd8;

	typedef logic [3:0] progress_t;

	// Characters of the upper-case label CHECKSUM.
	function automatic logic [7:0] key_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h43;
			3'd1: ch = 8'h48;
			3'd2: ch = 8'h45;
			3'd3: ch = 8'h43;
			3'd4: ch = 8'h4B;
			3'd5: ch = 8'h53;
			3'd6: ch = 8'h55;
			3'd7: ch = 8'h4D;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Fallback length after a mismatch with p characters matched, indexed by p-1.
	function automatic progress_t key_fail(input logic [2:0] idx);
		progress_t fb;
		case (idx)
			3'd3:    fb = 4'd1;
			default: fb = 4'd0;
		endcase
		return fb;
	endfunction

	// ASCII upper-case conversion.
	function automatic logic [7:0] to_upper(input logic [7:0] c);
		logic [7:0] u;
		if (c inside {[8'h61:8'h7A]}) begin
			u = c - 8'd32;
		end else begin
			u = c;
		end
		return u;
	endfunction

	// One matcher fallback step: drop back while the next key char differs.
	function automatic progress_t fall_back(input progress_t p, input logic [7:0] c);
		progress_t r;
		if ((p != 4'd0) && (key_char(p[2:0]) != c)) begin
			r = key_fail(p[2:0] - 3'd1);
		end else begin
			r = p;
		end
		return r;
	endfunction

	// Advance the progress by one character; the fallback chain is at most two deep.
	function automatic progress_t match_next(input progress_t p, input logic [7:0] c);
		progress_t q;
		q = (p >= KEY_LEN_W) ? 4'd0 : p;
		q = fall_back(q, c);
		q = fall_back(q, c);
		q = fall_back(q, c);
		if ((q < KEY_LEN_W) && (key_char(q[2:0]) == c)) begin
			q = q + 4'd1;
		end
		return q;
	endfunction

endpackage

@@ rtl/core/text_frame_checksum_parser.sv @@
// Top level of the text frame checksum parser.
// Depends on tfcp_pkg for codes, the label key and the matcher functions.
//
// Usage: the block takes one received byte per request on the input channel
// (in_valid, in_stall, rx_byte) and returns exactly one result per byte on
// the output channel (out_valid, out_stall, char_out, event_res, checksum_ok,
// checksum_residue). A request is taken at a rising edge where valid is high
// and stall is low.
// A byte accepted on the input channel sits in the input register, and its result
// is then registered in the result register and shown from then on. Throughput is
// one byte per cycle while the receiver does not stall; the parse state, running sum
// and label matcher all update in the single stage between input and result register.
// When the receiver stalls, the result register holds its result; the input
// register keeps the next byte, and in_stall rises only once both registers
// are full, so one byte can still be taken while a result waits.
// Reset clears both valid flags, returns the parser to idle and clears the
// running sum and the label matcher. No configuration is needed.
module text_frame_checksum_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] char_out,
	output logic [2:0] event_res,
	output logic       checksum_ok,
	output logic [7:0] checksum_residue
);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state.
	logic [1:0]          state_q;
	logic [7:0]          sum_q;
	tfcp_pkg::progress_t progress_q;
	logic                is_key_q;

	// Result register.
	logic       out_valid_q;
	logic [7:0] char_q;
	logic [2:0] event_q;
	logic       ok_q;
	logic [7:0] residue_q;

	// Next-state and result logic.
	logic                advance;
	logic                take_in;
	logic [7:0]          up_c;
	logic [7:0]          new_sum;
	logic [1:0]          state_d;
	logic [7:0]          sum_d;
	tfcp_pkg::progress_t progress_d;
	tfcp_pkg::progress_t progress_m;
	logic                is_key_d;
	logic [2:0]          event_d;
	logic                ok_d;

	// The stage moves forward when the result register is empty or being taken.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	assign up_c       = tfcp_pkg::to_upper(byte_s1);
	assign new_sum    = sum_q + byte_s1;
	assign progress_m = tfcp_pkg::match_next(progress_q, up_c);

	always_comb begin
		state_d    = state_q;
		sum_d      = new_sum;
		progress_d = progress_q;
		is_key_d   = is_key_q;
		event_d    = tfcp_pkg::EV_IGNORED;
		ok_d       = 1'b0;
		case (state_q)
			tfcp_pkg::ST_IDLE: begin
				// Bytes outside a frame only feed the sum until a newline opens one.
				if (up_c == tfcp_pkg::CH_LF) begin
					progress_d = 4'd0;
					is_key_d   = 1'b0;
					state_d    = tfcp_pkg::ST_NAME;
					event_d    = tfcp_pkg::EV_FRAME_START;
				end
			end
			tfcp_pkg::ST_NAME: begin
				if (up_c == tfcp_pkg::CH_TAB) begin
					state_d = is_key_q ? tfcp_pkg::ST_CHECK : tfcp_pkg::ST_VALUE;
					event_d = tfcp_pkg::EV_LABEL_END;
				end else begin
					// Once the key has been seen in this label the matcher freezes.
					if (!is_key_q) begin
						if (progress_m >= tfcp_pkg::KEY_LEN_W) begin
							progress_d = tfcp_pkg::KEY_LEN_W;
							is_key_d   = 1'b1;
						end else begin
							progress_d = progress_m;
						end
					end
					event_d = tfcp_pkg::EV_LABEL_CHAR;
				end
			end
			tfcp_pkg::ST_VALUE: begin
				if (up_c == tfcp_pkg::CH_LF) begin
					progress_d = 4'd0;
					is_key_d   = 1'b0;
					state_d    = tfcp_pkg::ST_NAME;
					event_d    = tfcp_pkg::EV_FIELD_END;
				end else if (up_c == tfcp_pkg::CH_CR) begin
					event_d = tfcp_pkg::EV_IGNORED;
				end else begin
					event_d = tfcp_pkg::EV_VALUE_CHAR;
				end
			end
			default: begin
				// The checksum byte closes the frame whatever its value.
				ok_d    = (new_sum == 8'd0);
				sum_d   = 8'd0;
				state_d = tfcp_pkg::ST_IDLE;
				event_d = tfcp_pkg::EV_CHECKED;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= tfcp_pkg::ST_IDLE;
			sum_q       <= 8'd0;
			progress_q  <= 4'd0;
			is_key_q    <= 1'b0;
		end else begin
			valid_s1    <= take_in || (valid_s1 && !advance);
			out_valid_q <= advance || (out_valid_q && out_stall);
			if (advance) begin
				state_q    <= state_d;
				sum_q      <= sum_d;
				progress_q <= progress_d;
				is_key_q   <= is_key_d;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= rx_byte;
		end
		if (advance) begin
			char_q    <= up_c;
			event_q   <= event_d;
			ok_q      <= ok_d;
			residue_q <= new_sum;
		end
	end

	assign out_valid        = out_valid_q;
	assign char_out         = char_q;
	assign event_res        = event_q;
	assign checksum_ok      = ok_q;
	assign checksum_residue = residue_q;

`ifndef SYNTHESIS
	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_ok_only_on_check: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ok_q) |-> (event_q == tfcp_pkg::EV_CHECKED))
		else $error("checksum_ok set on an event other than frame checked");

	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (state_q == tfcp_pkg::ST_CHECK)) |=>
		((sum_q == 8'd0) && (state_q == tfcp_pkg::ST_IDLE)))
		else $error("frame close did not clear the sum and return to idle");

	a_key_selects_check: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (state_q == tfcp_pkg::ST_NAME) && is_key_q &&
		(byte_s1 == tfcp_pkg::CH_TAB)) |=> (state_q == tfcp_pkg::ST_CHECK))
		else $error("checksum label did not lead to the checksum state");

	a_progress_range: assert property (@(posedge clk) disable iff (!arst_n)
		(progress_q <= tfcp_pkg::KEY_LEN_W) && (is_key_q == (progress_q == tfcp_pkg::KEY_LEN_W)))
		else $error("label match progress out of range or inconsistent with flag");
`endif

endmodule

@@ bench/text_frame_checksum_parser_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for text_frame_checksum_parser: drives link bytes and checks every result.
// Depends on tfcp_pkg for event, state and character codes, and on the block's RTL.
module text_frame_checksum_parser_test;

	// One expected or observed result of the parser.
	typedef struct {
		logic [7:0] ch;
		logic [2:0] ev;
		logic       ok;
		logic [7:0] residue;
	} parse_result_t;

	// The label that switches the parser into the checksum state, first character in the top byte.
	localparam logic [63:0] CHECKSUM_WORD = "CHECKSUM";
	// Random traffic stops once this many requests have gone in overall.
	localparam int RANDOM_BYTE_TARGET = 950;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] char_out;
	logic [2:0] event_res;
	logic       checksum_ok;
	logic [7:0] checksum_residue;

	// Expected results in request order, and the bookkeeping for the summary.
	parse_result_t expected_results[$];
	parse_result_t want;
	int bytes_sent = 0;
	int results_seen = 0;
	int frames_closed = 0;
	int frames_good = 0;
	int mismatches = 0;

	// While set, both sides insert random idle bursts; cleared for the last part of the run.
	bit traffic_gaps = 1'b1;
	// A nonzero value asks the receiver process to hold off for that many cycles.
	int hold_off_cycles = 0;

	// Predictor state: where the parser is in the frame, the running byte sum and the matcher.
	logic [1:0] frame_state = tfcp_pkg::ST_IDLE;
	logic [7:0] running_sum = 8'h00;
	logic [3:0] match_len = 4'd0;
	logic       label_has_key = 1'b0;

	text_frame_checksum_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_out(char_out),
		.event_res(event_res),
		.checksum_ok(checksum_ok),
		.checksum_residue(checksum_residue)
	);

	always #4 clk = ~clk;

	// A hard ceiling on the run; a healthy run finishes far sooner.
	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic [7:0] key_at(input logic [2:0] idx);
		return CHECKSUM_WORD[63 - 8 * idx -: 8];
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
	endfunction

	// Flips upper-case letters to lower case half of the time; other bytes pass through.
	function automatic logic [7:0] randomize_case(input logic [7:0] b);
		if (b >= 8'h41 && b <= 8'h5A && $urandom_range(0, 1) != 0) begin
			return b | 8'h20;
		end
		return b;
	endfunction

	// Feeds one upper-cased label character to the substring search for CHECKSUM.
	// Only a mismatch after CHEC has a nonzero fallback: the last C may start a new match.
	task automatic advance_match(input logic [7:0] c);
		logic [3:0] p;
		if (!label_has_key) begin
			p = (match_len >= 4'd8) ? 4'd0 : match_len;
			while (p != 4'd0 && key_at(p[2:0]) != c) begin
				p = (p == 4'd4) ? 4'd1 : 4'd0;
			end
			if (key_at(p[2:0]) == c) begin
				p = p + 4'd1;
			end
			if (p >= 4'd8) begin
				label_has_key = 1'b1;
				p = 4'd8;
			end
			match_len = p;
		end
	endtask

	// Works out the result of one accepted byte and moves the predictor state on.
	task automatic predict_parse_result(input logic [7:0] raw, output parse_result_t r);
		r.ch = upcase(raw);
		r.ev = tfcp_pkg::EV_IGNORED;
		r.ok = 1'b0;
		// Every raw byte enters the sum, even those ignored while idle.
		running_sum = running_sum + raw;
		r.residue = running_sum;
		case (frame_state)
			tfcp_pkg::ST_IDLE: begin
				if (r.ch == tfcp_pkg::CH_LF) begin
					match_len = 4'd0;
					label_has_key = 1'b0;
					frame_state = tfcp_pkg::ST_NAME;
					r.ev = tfcp_pkg::EV_FRAME_START;
				end
			end
			tfcp_pkg::ST_NAME: begin
				// Newline and carriage return are ordinary label characters here.
				if (r.ch == tfcp_pkg::CH_TAB) begin
					frame_state = label_has_key ? tfcp_pkg::ST_CHECK : tfcp_pkg::ST_VALUE;
					r.ev = tfcp_pkg::EV_LABEL_END;
				end else begin
					advance_match(r.ch);
					r.ev = tfcp_pkg::EV_LABEL_CHAR;
				end
			end
			tfcp_pkg::ST_VALUE: begin
				if (r.ch == tfcp_pkg::CH_LF) begin
					match_len = 4'd0;
					label_has_key = 1'b0;
					frame_state = tfcp_pkg::ST_NAME;
					r.ev = tfcp_pkg::EV_FIELD_END;
				end else if (r.ch == tfcp_pkg::CH_CR) begin
					r.ev = tfcp_pkg::EV_IGNORED;
				end else begin
					r.ev = tfcp_pkg::EV_VALUE_CHAR;
				end
			end
			default: begin
				// Whatever byte follows the checksum label closes the frame.
				r.ok = (running_sum == 8'h00);
				running_sum = 8'h00;
				frame_state = tfcp_pkg::ST_IDLE;
				r.ev = tfcp_pkg::EV_CHECKED;
			end
		endcase
	endtask

	// Offers one byte, possibly after a random idle burst, and waits for the block to take it.
	// Valid stays high afterwards so back-to-back requests follow without a gap; the caller
	// lowers it through wait_for_results when a test is done.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		parse_result_t r;
		if (traffic_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		predict_parse_result(b, r);
		expected_results.push_back(r);
		bytes_sent++;
	endtask

	// Stops offering requests and lets every outstanding result come back.
	task automatic wait_for_results;
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Label characters lean toward the letters of CHECKSUM so that partial matches are common.
	// Now and then a carriage return or newline lands inside a label.
	function automatic logic [7:0] label_char();
		logic [7:0] c;
		case ($urandom_range(0, 7))
			0, 1, 2: c = key_at(3'($urandom_range(0, 7)));
			3, 4:    c = 8'h41 + 8'($urandom_range(0, 25));
			5:       c = 8'h30 + 8'($urandom_range(0, 9));
			6:       c = 8'h5F;
			default: c = ($urandom_range(0, 1) != 0) ? tfcp_pkg::CH_CR : tfcp_pkg::CH_LF;
		endcase
		return randomize_case(c);
	endfunction

	// Value characters are mostly printable, with tabs and carriage returns mixed in.
	function automatic logic [7:0] value_char();
		case ($urandom_range(0, 9))
			0:       return tfcp_pkg::CH_CR;
			1:       return tfcp_pkg::CH_TAB;
			2:       return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(8'h20, 8'h7E));
		endcase
	endfunction

	// Bytes for broken frames, rich in the characters that move the parse state.
	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 5))
			0:       return tfcp_pkg::CH_TAB;
			1:       return tfcp_pkg::CH_LF;
			2:       return tfcp_pkg::CH_CR;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Sends a whole frame: opening newline, some fields, a checksum label in one of several
	// shapes and the closing byte, which makes the sum zero when good_sum is set.
	task automatic send_frame(input int n_fields, input bit good_sum);
		int i;
		int j;
		int len;
		int shape;
		send_byte(tfcp_pkg::CH_LF);
		for (i = 0; i < n_fields; i++) begin
			len = $urandom_range(1, 7);
			for (j = 0; j < len; j++) send_byte(label_char());
			send_byte(tfcp_pkg::CH_TAB);
			len = $urandom_range(0, 8);
			for (j = 0; j < len; j++) send_byte(value_char());
			send_byte(tfcp_pkg::CH_LF);
		end
		// Shape 0 wraps the word in other characters, shape 1 repeats its first four letters
		// in front so the matcher has to fall back; the rest is the plain word.
		shape = $urandom_range(0, 5);
		if (shape == 0) send_byte(label_char());
		if (shape == 1) begin
			for (j = 0; j < 4; j++) send_byte(randomize_case(key_at(3'(j))));
		end
		for (j = 0; j < 8; j++) send_byte(randomize_case(key_at(3'(j))));
		if (shape == 0) send_byte(label_char());
		send_byte(tfcp_pkg::CH_TAB);
		send_byte(good_sum ? 8'd0 - running_sum : 8'($urandom_range(0, 255)));
	endtask

	task automatic report_mismatch(input string field, input logic [7:0] exp_v,
		input logic [7:0] got_v);
		$display("%0t: %s expected %h, got %h", $time, field, exp_v, got_v);
		mismatches++;
	endtask

	// Compares every result the block hands over with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (event_res == tfcp_pkg::EV_CHECKED) begin
				frames_closed++;
				if (checksum_ok) frames_good++;
			end
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected: char_out %h event_res %0d",
					$time, char_out, event_res);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (char_out !== want.ch)
					report_mismatch("char_out", want.ch, char_out);
				if (event_res !== want.ev)
					report_mismatch("event_res", 8'(want.ev), 8'(event_res));
				if (checksum_ok !== want.ok)
					report_mismatch("checksum_ok", 8'(want.ok), 8'(checksum_ok));
				if (checksum_residue !== want.residue)
					report_mismatch("checksum_residue", want.residue, checksum_residue);
			end
		end
	end

	// The receiver stalls in random bursts, or for a long stretch when a test asks for one.
	// Each pass through the loop drives out_stall at most once per clock edge.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
				out_stall <= 1'b0;
			end else if (traffic_gaps && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// One hand-built frame: extreme bytes while idle, the case-conversion bounds,
	// carriage return and newline inside a label, a tab and a carriage return inside
	// a value, a field end, and a checksum label written as CHEChecKSUM, whose false
	// start makes the matcher fall back. The closing byte brings the sum to zero.
	task automatic test_directed_frame;
		logic [87:0] word;
		int i;
		word = "CHEChecKSUM";
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(tfcp_pkg::CH_LF);
		send_byte(8'h61);
		send_byte(tfcp_pkg::CH_CR);
		send_byte(tfcp_pkg::CH_LF);
		send_byte(tfcp_pkg::CH_TAB);
		send_byte(tfcp_pkg::CH_TAB);
		send_byte(8'hFF);
		send_byte(tfcp_pkg::CH_CR);
		send_byte(tfcp_pkg::CH_LF);
		send_byte(8'h7A);
		for (i = 0; i < 11; i++) send_byte(word[87 - 8 * i -: 8]);
		send_byte(tfcp_pkg::CH_TAB);
		send_byte(8'd0 - running_sum);
		wait_for_results();
	endtask

	// Mostly well-formed frames with random content and good or bad sums, with idle
	// noise and truncated frames mixed in.
	task automatic test_random_traffic;
		while (bytes_sent < RANDOM_BYTE_TARGET) begin
			case ($urandom_range(0, 9))
				0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
				1: begin
					send_byte(tfcp_pkg::CH_LF);
					repeat ($urandom_range(1, 10)) send_byte(noise_byte());
				end
				default: send_frame(int'($urandom_range(0, 4)), $urandom_range(0, 3) != 0);
			endcase
		end
		wait_for_results();
	endtask

	// The receiver holds off for a long stretch while a frame keeps coming, so both
	// registers of the block fill and it must stall its input.
	task automatic test_output_hold;
		hold_off_cycles = 60;
		send_frame(3, 1'b1);
		wait_for_results();
	endtask

	// The last part of the run: no idling on either side, one request per cycle.
	task automatic test_full_rate;
		traffic_gaps = 1'b0;
		repeat (3) send_frame(3, 1'b1);
		send_frame(1, 1'b0);
		wait_for_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_frame();
		test_random_traffic();
		test_output_hold();
		test_full_rate();
		$display("Sent %0d bytes and checked %0d results.", bytes_sent, results_seen);
		$display("%0d frames were closed, %0d with a zero sum.", frames_closed, frames_good);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ text_frame_checksum_parser.f @@
rtl/core/tfcp_pkg.sv
rtl/core/text_frame_checksum_parser.sv
bench/text_frame_checksum_parser_test.sv
